FILE: rtl/xed_pkg.sv
// Shared types, character constants and lookup functions of the XML entity decoder.
// No dependencies; used by every file under rtl.
package xed_pkg;

  localparam int CP_W = 21;
  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

  // longest held prefix of a named entity: "&nbsp"
  localparam int NAMED_LEN = 5;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [4:0] {
    PH_IDLE, PH_AMP, PH_HASH, PH_DIG,
    PH_N, PH_NB, PH_NBS, PH_NBSP,
    PH_A, PH_AM, PH_AMPX, PH_AP, PH_APO, PH_APOS,
    PH_Q, PH_QU, PH_QUO, PH_QUOT,
    PH_L, PH_LT, PH_G, PH_GT
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_TAIL
  } seq_state_t;

  typedef struct packed {
    logic       hit;
    logic       done;
    phase_t     nxt;
    logic [7:0] ch;
  } arc_t;

  typedef struct packed {
    logic       from_pend;
    logic       lit;
    logic [1:0] last;
    logic [1:0] idx;
  } emit_ctl_t;

  function automatic arc_t arc_go(phase_t nxt);
    arc_t a;
    a.hit  = 1'b1;
    a.done = 1'b0;
    a.nxt  = nxt;
    a.ch   = '0;
    return a;
  endfunction

  function automatic arc_t arc_fin(logic [7:0] ch);
    arc_t a;
    a.hit  = 1'b1;
    a.done = 1'b1;
    a.nxt  = PH_IDLE;
    a.ch   = ch;
    return a;
  endfunction

  // Named-entity transitions; numeric phases are handled by the caller.
  function automatic arc_t arc_lookup(phase_t ph, logic [7:0] b);
    arc_t a;
    a.hit  = 1'b0;
    a.done = 1'b0;
    a.nxt  = PH_IDLE;
    a.ch   = '0;
    unique case (ph)
      PH_IDLE: if (b == CH_AMP) a = arc_go(PH_AMP);
      PH_AMP: begin
        if (b == CH_HASH) a = arc_go(PH_HASH);
        else if (b == "n") a = arc_go(PH_N);
        else if (b == "a") a = arc_go(PH_A);
        else if (b == "q") a = arc_go(PH_Q);
        else if (b == "l") a = arc_go(PH_L);
        else if (b == "g") a = arc_go(PH_G);
      end
      PH_N:    if (b == "b") a = arc_go(PH_NB);
      PH_NB:   if (b == "s") a = arc_go(PH_NBS);
      PH_NBS:  if (b == "p") a = arc_go(PH_NBSP);
      PH_NBSP: if (b == CH_SEMI) a = arc_fin(CH_SPACE);
      PH_A: begin
        if (b == "m") a = arc_go(PH_AM);
        else if (b == "p") a = arc_go(PH_AP);
      end
      PH_AM:   if (b == "p") a = arc_go(PH_AMPX);
      PH_AMPX: if (b == CH_SEMI) a = arc_fin(CH_AMP);
      PH_AP:   if (b == "o") a = arc_go(PH_APO);
      PH_APO:  if (b == "s") a = arc_go(PH_APOS);
      PH_APOS: if (b == CH_SEMI) a = arc_fin(CH_APOS);
      PH_Q:    if (b == "u") a = arc_go(PH_QU);
      PH_QU:   if (b == "o") a = arc_go(PH_QUO);
      PH_QUO:  if (b == "t") a = arc_go(PH_QUOT);
      PH_QUOT: if (b == CH_SEMI) a = arc_fin(CH_QUOT);
      PH_L:    if (b == "t") a = arc_go(PH_LT);
      PH_LT:   if (b == CH_SEMI) a = arc_fin(CH_LT);
      PH_G:    if (b == "t") a = arc_go(PH_GT);
      PH_GT:   if (b == CH_SEMI) a = arc_fin(CH_GT);
      default: ;
    endcase
    return a;
  endfunction

  // Index of the last UTF-8 byte for a code point (0 to 3).
  function automatic logic [1:0] utf8_last(logic [CP_W-1:0] cp);
    logic [1:0] l;
    priority if (cp < 21'h80) l = 2'd0;
    else if (cp < 21'h800) l = 2'd1;
    else if (cp < 21'h10000) l = 2'd2;
    else l = 2'd3;
    return l;
  endfunction

endpackage

FILE: rtl/xed_acc.sv
// Decimal accumulate unit: code point times ten plus one digit, saturating.
// Depends on xed_pkg.
module xed_acc (
  input  logic [xed_pkg::CP_W-1:0] cp_in,
  input  logic [3:0]               digit,
  output logic [xed_pkg::CP_W-1:0] cp_out
);

  localparam int SUM_W = xed_pkg::CP_W + 4;

  logic [SUM_W-1:0] sum;

  // x*10 = x*8 + x*2
  assign sum = {1'b0, cp_in, 3'b000} + {3'b000, cp_in, 1'b0} + SUM_W'(digit);

  assign cp_out = (sum > SUM_W'(xed_pkg::CP_MAX)) ? xed_pkg::CP_MAX
                                                  : sum[xed_pkg::CP_W-1:0];

endmodule

FILE: rtl/xed_emit.sv
// Output byte former: picks a held byte, a literal byte or one UTF-8 byte.
// Depends on xed_pkg.
module xed_emit (
  input  xed_pkg::emit_ctl_t       ctl,
  input  logic [7:0]               pend_byte,
  input  logic [xed_pkg::CP_W-1:0] tail_cp,
  output logic [7:0]               emit_byte
);

  always_comb begin
    priority if (ctl.from_pend) begin
      emit_byte = pend_byte;
    end else if (ctl.lit) begin
      emit_byte = tail_cp[7:0];
    end else begin
      unique case ({ctl.last, ctl.idx})
        4'b00_00: emit_byte = {1'b0, tail_cp[6:0]};
        4'b01_00: emit_byte = {3'b110, tail_cp[10:6]};
        4'b01_01: emit_byte = {2'b10, tail_cp[5:0]};
        4'b10_00: emit_byte = {4'b1110, tail_cp[15:12]};
        4'b10_01: emit_byte = {2'b10, tail_cp[11:6]};
        4'b10_10: emit_byte = {2'b10, tail_cp[5:0]};
        4'b11_00: emit_byte = {5'b11110, tail_cp[20:18]};
        4'b11_01: emit_byte = {2'b10, tail_cp[17:12]};
        4'b11_10: emit_byte = {2'b10, tail_cp[11:6]};
        4'b11_11: emit_byte = {2'b10, tail_cp[5:0]};
        default:  emit_byte = '0;
      endcase
    end
  end

endmodule

FILE: rtl/xml_entity_decoder_core.sv
// XML character entity decoder, top level. A byte is taken while the sequencer is idle; its
// output beats follow from the flush and tail states. An item giving k output bytes stalls
// the input until they are sent (k up to PEND_DEPTH + 1); a byte only held does not stall.
// The single output register emits one beat per cycle unless out_stall is high, which sets the drain rate.
// Reset (rst, synchronous, active high) returns to idle with nothing pending; the
// pending buffer itself is not cleared, only its fill count.
// Depends on xed_pkg, xed_acc and xed_emit.
module xml_entity_decoder_core #(
  parameter int MAX_DIGITS = 7
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       text_done
);

  // Buffer holds "&#" plus digits, or the longest named prefix.
  localparam int PEND_DEPTH = (MAX_DIGITS + 2 > xed_pkg::NAMED_LEN) ? MAX_DIGITS + 2
                                                                   : xed_pkg::NAMED_LEN;
  localparam int CNT_W = $clog2(PEND_DEPTH + 1);
  localparam int IDX_W = $clog2(PEND_DEPTH);
  localparam int DIG_W = $clog2(MAX_DIGITS + 1);
  localparam int CPW   = xed_pkg::CP_W;

  // Sequencer and match state
  xed_pkg::seq_state_t state, state_next;
  xed_pkg::phase_t     phase, phase_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CPW-1:0]      cp, cp_next;
  logic [DIG_W-1:0]    dcount, dcount_next;

  // Pending buffer
  logic [7:0]          pend [PEND_DEPTH];
  logic                pend_we;

  // Current job: flush of held bytes, then an optional tail
  logic [CNT_W-1:0]    flush_n, flush_n_next;
  logic [CNT_W-1:0]    pos, pos_next;
  logic                tail_on, tail_on_next;
  logic                tail_lit, tail_lit_next;
  logic [CPW-1:0]      tail_cp, tail_cp_next;
  logic [1:0]          tail_last, tail_last_next;
  logic [1:0]          tidx, tidx_next;
  logic                job_end, job_end_next;

  // Output register
  logic                out_valid_next;
  logic [7:0]          out_byte_next;
  logic                run_last_next;
  logic                text_done_next;

  logic                accept;
  logic                out_free;
  logic                is_dig;
  logic                hold_first;
  logic                hold_more;
  logic                hold;
  logic                num_done;
  logic                named_done;
  logic                flush_last;
  logic                tail_final;
  logic                beat_last;
  logic [CPW-1:0]      acc_cp;
  logic [CPW-1:0]      done_cp;
  logic [7:0]          emit_byte;
  logic [7:0]          pend_byte;
  xed_pkg::arc_t       arc;
  xed_pkg::emit_ctl_t  emit_ctl;

  assign in_stall = (state != xed_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Classify the incoming byte against the match state
  assign is_dig     = (in_byte >= xed_pkg::CH_ZERO) && (in_byte <= xed_pkg::CH_NINE);
  assign arc        = xed_pkg::arc_lookup(phase, in_byte);
  assign hold_first = (phase == xed_pkg::PH_HASH) && is_dig;
  assign hold_more  = (phase == xed_pkg::PH_DIG) && is_dig
                      && (dcount < DIG_W'(MAX_DIGITS));
  assign num_done   = (phase == xed_pkg::PH_DIG) && (in_byte == xed_pkg::CH_SEMI);
  assign named_done = arc.hit && arc.done;
  assign hold       = hold_first || hold_more || (arc.hit && !arc.done);
  assign done_cp    = num_done ? cp : CPW'(arc.ch);

  // Shared digit unit: the code point register is zero on the first digit
  xed_acc u_acc (
    .cp_in  (cp),
    .digit  (in_byte[3:0]),
    .cp_out (acc_cp)
  );

  always_comb begin
    emit_ctl.from_pend = (state == xed_pkg::ST_FLUSH);
    emit_ctl.lit       = tail_lit;
    emit_ctl.last      = tail_last;
    emit_ctl.idx       = tidx;
  end

  xed_emit u_emit (
    .ctl       (emit_ctl),
    .pend_byte (pend_byte),
    .tail_cp   (tail_cp),
    .emit_byte (emit_byte)
  );

  assign flush_last = (pos == flush_n - CNT_W'(1));
  assign tail_final = (tidx == tail_last);

  // Next state of the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      xed_pkg::ST_IDLE: begin
        if (accept && (flush_n_next != '0 || tail_on_next)) begin
          state_next = (flush_n_next != '0) ? xed_pkg::ST_FLUSH : xed_pkg::ST_TAIL;
        end
      end
      xed_pkg::ST_FLUSH: begin
        if (out_free && flush_last) begin
          state_next = tail_on ? xed_pkg::ST_TAIL : xed_pkg::ST_IDLE;
        end
      end
      xed_pkg::ST_TAIL: begin
        if (out_free && tail_final) begin
          state_next = xed_pkg::ST_IDLE;
        end
      end
      default: state_next = xed_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    phase_next     = phase;
    count_next     = count;
    cp_next        = cp;
    dcount_next    = dcount;
    pend_we        = 1'b0;
    flush_n_next   = flush_n;
    pos_next       = pos;
    tail_on_next   = tail_on;
    tail_lit_next  = tail_lit;
    tail_cp_next   = tail_cp;
    tail_last_next = tail_last;
    tidx_next      = tidx;
    job_end_next   = job_end;
    out_valid_next = out_valid && out_stall;
    out_byte_next  = out_byte;
    run_last_next  = run_last;
    text_done_next = text_done;
    beat_last      = 1'b0;

    unique case (state)
      xed_pkg::ST_IDLE: begin
        if (accept) begin
          // Set up a fresh job: literal tail of the input byte by default
          job_end_next   = in_end;
          pos_next       = '0;
          tidx_next      = '0;
          flush_n_next   = '0;
          tail_on_next   = 1'b0;
          tail_lit_next  = 1'b1;
          tail_cp_next   = CPW'(in_byte);
          tail_last_next = '0;

          priority if (hold) begin
            if (in_end) begin
              // Held prefix plus this byte go out literally
              flush_n_next = count;
              tail_on_next = 1'b1;
              phase_next   = xed_pkg::PH_IDLE;
              count_next   = '0;
              cp_next      = '0;
              dcount_next  = '0;
            end else begin
              pend_we    = 1'b1;
              count_next = count + CNT_W'(1);
              if (hold_first || hold_more) begin
                phase_next  = xed_pkg::PH_DIG;
                cp_next     = acc_cp;
                dcount_next = hold_first ? DIG_W'(1) : dcount + DIG_W'(1);
              end else begin
                phase_next = arc.nxt;
              end
            end
          end else if (num_done || named_done) begin
            // Entity complete: drop the prefix, send the character
            tail_on_next   = 1'b1;
            tail_lit_next  = 1'b0;
            tail_cp_next   = done_cp;
            tail_last_next = xed_pkg::utf8_last(done_cp);
            phase_next     = xed_pkg::PH_IDLE;
            count_next     = '0;
            cp_next        = '0;
            dcount_next    = '0;
          end else begin
            // Broken entity: flush the prefix, then handle the byte afresh
            flush_n_next = count;
            tail_on_next = (in_byte != xed_pkg::CH_AMP) || in_end;
            cp_next      = '0;
            dcount_next  = '0;
            if (in_byte == xed_pkg::CH_AMP && !in_end) begin
              // Entry zero already holds the ampersand
              phase_next = xed_pkg::PH_AMP;
              count_next = CNT_W'(1);
            end else begin
              phase_next = xed_pkg::PH_IDLE;
              count_next = '0;
            end
          end
        end
      end
      xed_pkg::ST_FLUSH: begin
        if (out_free) begin
          beat_last      = flush_last && !tail_on;
          out_valid_next = 1'b1;
          out_byte_next  = emit_byte;
          run_last_next  = beat_last;
          text_done_next = beat_last && job_end;
          pos_next       = pos + CNT_W'(1);
        end
      end
      xed_pkg::ST_TAIL: begin
        if (out_free) begin
          beat_last      = tail_final;
          out_valid_next = 1'b1;
          out_byte_next  = emit_byte;
          run_last_next  = beat_last;
          text_done_next = beat_last && job_end;
          tidx_next      = tidx + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= xed_pkg::ST_IDLE;
      phase     <= xed_pkg::PH_IDLE;
      count     <= '0;
      cp        <= '0;
      dcount    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      count     <= count_next;
      cp        <= cp_next;
      dcount    <= dcount_next;
      out_valid <= out_valid_next;
    end
  end

  // Job and beat payload
  always_ff @(posedge clk) begin
    flush_n   <= flush_n_next;
    pos       <= pos_next;
    tail_on   <= tail_on_next;
    tail_lit  <= tail_lit_next;
    tail_cp   <= tail_cp_next;
    tail_last <= tail_last_next;
    tidx      <= tidx_next;
    job_end   <= job_end_next;
    out_byte  <= out_byte_next;
    run_last  <= run_last_next;
    text_done <= text_done_next;
  end

  // Pending buffer: append at the fill count; the read is registered from the next
  // drain position, so the held byte is ready when the flush beat is formed
  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend[count[IDX_W-1:0]] <= in_byte;
    end
    pend_byte <= pend[pos_next[IDX_W-1:0]];
  end

  // Held prefix never outgrows the buffer
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(PEND_DEPTH))
    else $error("pending count beyond buffer depth");

  // Digit count only lives inside a numeric reference
  assert property (@(posedge clk) disable iff (rst)
    (phase != xed_pkg::PH_DIG) |-> (dcount == '0))
    else $error("digit count set outside a numeric reference");

  // Saturation keeps the code point in range
  assert property (@(posedge clk) disable iff (rst)
    cp <= xed_pkg::CP_MAX)
    else $error("code point above the Unicode range");

  // The final beat of a text leaves nothing pending
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && text_done) |->
      (phase == xed_pkg::PH_IDLE && count == '0))
    else $error("bytes still pending at end of text");

endmodule
